// File: rtl/flptb_pkg.sv
// Shared types and constants of the four-level page table builder.
// Field widths, register indexes and descriptor encodings; no dependencies.
package flptb_pkg;

  localparam int unsigned ENTRIES_PER_TABLE = 512;
  localparam int unsigned IDX_W             = 9;
  localparam int unsigned PN_W              = 36;
  localparam int unsigned FLAGS_W           = 12;
  localparam int unsigned WIDX_W            = 13;
  localparam int unsigned WORD_W            = 64;
  localparam int unsigned COUNT_W           = 5;
  localparam int unsigned CFG_IDX_W         = 2;
  localparam int unsigned CFG_DATA_W        = 36;

  localparam logic [CFG_IDX_W-1:0] REG_POOL_BASE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POOL_COUNT = 2'd1;

  localparam logic [COUNT_W-1:0] POOL_COUNT_RESET = 5'd16;

  localparam logic [1:0] TABLE_DESC = 2'b11;

  typedef enum logic [0:0] {
    FUNC_MAP  = 1'b0,
    FUNC_READ = 1'b1
  } func_e;

  typedef struct packed {
    logic              status;
    logic [WORD_W-1:0] read_data;
  } result_t;

endpackage

// File: rtl/flptb_mem.sv
// Table pool storage: one port, synchronous read.
// Depends on flptb_pkg for the word width.
module flptb_mem import flptb_pkg::*; #(
  parameter int unsigned ADDR_W = 13
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] addr_i,
  input  logic [WORD_W-1:0] wdata_i,
  output logic [WORD_W-1:0] rdata_o
);

  logic [WORD_W-1:0] mem [2**ADDR_W];
  logic [WORD_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/flptb_walk.sv
// Table walk sequencer: clears the root table after reset, reads pool words, walks levels 0 to 2,
// takes and clears pool pages, writes descriptors and leaves. Depends on flptb_pkg; drives flptb_mem.
module flptb_walk import flptb_pkg::*; #(
  parameter int unsigned POOL_PAGES = 16,
  localparam int unsigned PG_W      = $clog2(POOL_PAGES),
  localparam int unsigned PGC_W     = $clog2(POOL_PAGES + 1),
  localparam int unsigned ADDR_W    = PG_W + IDX_W
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               func_i,
  input  logic [PN_W-1:0]    page_number_i,
  input  logic [FLAGS_W-1:0] page_flags_i,
  input  logic [WIDX_W-1:0]  word_index_i,
  input  logic [PN_W-1:0]    pool_base_i,
  input  logic [PGC_W-1:0]   page_limit_i,
  output logic               res_valid_o,
  input  logic               res_ready_i,
  output result_t            res_o,
  output logic               mem_we_o,
  output logic [ADDR_W-1:0]  mem_addr_o,
  output logic [WORD_W-1:0]  mem_wdata_o,
  input  logic [WORD_W-1:0]  mem_rdata_i
);

  typedef enum logic [2:0] {
    S_BOOT, S_IDLE, S_RD, S_EV, S_CLR, S_LEAF, S_OUT
  } state_e;

  localparam logic [1:0] LVL_0 = 2'd0;
  localparam logic [1:0] LVL_1 = 2'd1;
  localparam logic [1:0] LVL_2 = 2'd2;

  function automatic logic [IDX_W-1:0] slot_sel(input logic [1:0] lvl,
                                                 input logic [PN_W-1:0] pn);
    logic [IDX_W-1:0] s;
    unique case (lvl)
      LVL_0:   s = pn[35:27];
      LVL_1:   s = pn[26:18];
      LVL_2:   s = pn[17:9];
      default: s = pn[8:0];
    endcase
    return s;
  endfunction

  state_e             state_q, state_d;
  logic [1:0]         level_q, level_d;
  logic [PG_W-1:0]    page_q, page_d;
  logic [PGC_W-1:0]   nfp_q, nfp_d;
  logic [IDX_W-1:0]   cnt_q, cnt_d;
  logic               func_q;
  logic [PN_W-1:0]    pn_q;
  logic [FLAGS_W-1:0] flags_q;
  logic [WIDX_W-1:0]  widx_q;
  result_t            res_q, res_d;

  logic               accept;
  logic [31:0]        widx_ext;
  logic               word_taken;
  logic [PN_W-1:0]    rel;
  logic               rel_ok;
  logic               take_ok;
  logic [PG_W-1:0]    child;
  logic [PN_W-1:0]    desc_page;
  logic [WORD_W-1:0]  desc_word;
  logic [WORD_W-1:0]  leaf_word;
  logic [IDX_W-1:0]   cur_slot;
  logic [IDX_W-1:0]   next_slot;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);

  assign widx_ext   = 32'(widx_q);
  assign word_taken = (widx_ext >> IDX_W) < 32'(nfp_q);
  assign rel        = mem_rdata_i[47:12] - pool_base_i;
  assign rel_ok     = rel < PN_W'(nfp_q);
  assign take_ok    = nfp_q < page_limit_i;
  assign child      = rel[PG_W-1:0];
  assign desc_page  = pool_base_i + PN_W'(nfp_q);
  assign desc_word  = {16'd0, desc_page, 10'd0, TABLE_DESC};
  assign leaf_word  = {16'd0, pn_q, flags_q};
  assign cur_slot   = slot_sel(level_q, pn_q);
  assign next_slot  = slot_sel(level_q + 2'd1, pn_q);

  assign res_valid_o = (state_q == S_OUT);
  assign res_o       = res_q;

  always_comb begin
    state_d     = state_q;
    level_d     = level_q;
    page_d      = page_q;
    nfp_d       = nfp_q;
    cnt_d       = cnt_q;
    res_d       = res_q;
    mem_we_o    = 1'b0;
    mem_addr_o  = {page_q, cur_slot};
    mem_wdata_o = '0;
    unique case (state_q)
      S_BOOT: begin
        mem_we_o   = 1'b1;
        mem_addr_o = {page_q, cnt_q};
        cnt_d      = cnt_q + 1'b1;
        if (&cnt_q) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_d = S_RD;
          level_d = LVL_0;
          page_d  = '0;
        end
      end
      S_RD: begin
        if (func_q == FUNC_READ) begin
          mem_addr_o = widx_ext[ADDR_W-1:0];
        end
        state_d = S_EV;
      end
      S_EV: begin
        if (func_q == FUNC_READ) begin
          res_d.status    = 1'b0;
          res_d.read_data = word_taken ? mem_rdata_i : '0;
          state_d         = S_OUT;
        end else if (mem_rdata_i == '0) begin
          if (!take_ok) begin
            res_d.status    = 1'b1;
            res_d.read_data = '0;
            state_d         = S_OUT;
          end else begin
            mem_we_o    = 1'b1;
            mem_wdata_o = desc_word;
            nfp_d       = nfp_q + PGC_W'(1);
            page_d      = nfp_q[PG_W-1:0];
            cnt_d       = '0;
            state_d     = S_CLR;
          end
        end else if (!rel_ok) begin
          res_d.status    = 1'b1;
          res_d.read_data = '0;
          state_d         = S_OUT;
        end else if (level_q == LVL_2) begin
          mem_we_o        = 1'b1;
          mem_addr_o      = {child, pn_q[IDX_W-1:0]};
          mem_wdata_o     = leaf_word;
          res_d.status    = 1'b0;
          res_d.read_data = '0;
          state_d         = S_OUT;
        end else begin
          level_d    = level_q + 2'd1;
          page_d     = child;
          mem_addr_o = {child, next_slot};
        end
      end
      S_CLR: begin
        mem_we_o   = 1'b1;
        mem_addr_o = {page_q, cnt_q};
        cnt_d      = cnt_q + 1'b1;
        if (&cnt_q) begin
          if (level_q == LVL_2) begin
            state_d = S_LEAF;
          end else begin
            level_d = level_q + 2'd1;
            state_d = S_RD;
          end
        end
      end
      S_LEAF: begin
        mem_we_o        = 1'b1;
        mem_addr_o      = {page_q, pn_q[IDX_W-1:0]};
        mem_wdata_o     = leaf_word;
        res_d.status    = 1'b0;
        res_d.read_data = '0;
        state_d         = S_OUT;
      end
      S_OUT: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_BOOT;
      level_q <= LVL_0;
      page_q  <= '0;
      nfp_q   <= PGC_W'(1);
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      level_q <= level_d;
      page_q  <= page_d;
      nfp_q   <= nfp_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q  <= func_i;
      pn_q    <= page_number_i;
      flags_q <= page_flags_i;
      widx_q  <= word_index_i;
    end
    res_q <= res_d;
  end

endmodule

// File: rtl/four_level_page_table_builder.sv
// Four-level page table builder: config registers, output register, and
// the walk sequencer with its table pool. Depends on flptb_pkg,
// flptb_walk and flptb_mem.
//
// Input channel (in_valid_i / in_stall_o) takes one word per item: func 0
// maps page_number_i identically with page_flags_i in the leaf, func 1
// reads pool word word_index_i. Each item returns one word on the output
// channel (out_valid_o / out_stall_i): status 1 when the pool runs out or a
// descriptor points outside the taken pool pages, read_data for read items.
// Config port (cfg_valid_i / cfg_ready_o) sets the pool base page and page
// count; write it only while idle. After reset the root table is cleared
// with in_stall_o high. A map item that finds every level present makes
// three dependent reads of the single-port pool memory plus the leaf write.
// Each new table page adds one store port write per cleared word. One item
// is in flight at a time. A stalled result sits in the output register;
// the walker holds its next result until that register drains.
module four_level_page_table_builder import flptb_pkg::*; #(
  parameter int unsigned POOL_PAGES = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  func_i,
  input  logic [PN_W-1:0]       page_number_i,
  input  logic [FLAGS_W-1:0]    page_flags_i,
  input  logic [WIDX_W-1:0]     word_index_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  status_o,
  output logic [WORD_W-1:0]     read_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned PG_W   = $clog2(POOL_PAGES);
  localparam int unsigned PGC_W  = $clog2(POOL_PAGES + 1);
  localparam int unsigned ADDR_W = PG_W + IDX_W;

  logic [PN_W-1:0]    pool_base_q;
  logic [COUNT_W-1:0] pool_count_q;
  logic [PGC_W-1:0]   page_limit;
  logic               out_valid_q;
  result_t            out_q;
  logic               res_valid;
  logic               res_ready;
  result_t            res;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_addr;
  logic [WORD_W-1:0]  mem_wdata;
  logic [WORD_W-1:0]  mem_rdata;

  assign cfg_ready_o = 1'b1;
  assign page_limit  = (32'(pool_count_q) > POOL_PAGES) ? PGC_W'(POOL_PAGES)
                                                         : PGC_W'(pool_count_q);
  assign res_ready   = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign status_o    = out_q.status;
  assign read_data_o = out_q.read_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_base_q  <= '0;
      pool_count_q <= POOL_COUNT_RESET;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == REG_POOL_BASE) begin
          pool_base_q <= cfg_data_i;
        end else if (cfg_index_i == REG_POOL_COUNT) begin
          pool_count_q <= cfg_data_i[COUNT_W-1:0];
        end
      end
      if (res_valid && res_ready) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  flptb_walk #(
    .POOL_PAGES(POOL_PAGES)
  ) u_walk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .func_i        (func_i),
    .page_number_i (page_number_i),
    .page_flags_i  (page_flags_i),
    .word_index_i  (word_index_i),
    .pool_base_i   (pool_base_q),
    .page_limit_i  (page_limit),
    .res_valid_o   (res_valid),
    .res_ready_i   (res_ready),
    .res_o         (res),
    .mem_we_o      (mem_we),
    .mem_addr_o    (mem_addr),
    .mem_wdata_o   (mem_wdata),
    .mem_rdata_i   (mem_rdata)
  );

  flptb_mem #(
    .ADDR_W(ADDR_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

endmodule

// File: tb/tb_four_level_page_table_builder.sv
`timescale 1ns / 100ps
// Testbench for four_level_page_table_builder: drives map and read words, predicts
// every result from its own copy of the table pool, and compares in order.
// Depends on flptb_pkg and the RTL of the block; needs nothing else.
module tb_four_level_page_table_builder;
  import flptb_pkg::*;

  localparam int unsigned POOL_PAGES  = 16;
  localparam int unsigned STORE_WORDS = POOL_PAGES * ENTRIES_PER_TABLE;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic                  func_i;
  logic [PN_W-1:0]       page_number_i;
  logic [FLAGS_W-1:0]    page_flags_i;
  logic [WIDX_W-1:0]     word_index_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic                  status_o;
  logic [WORD_W-1:0]     read_data_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  logic [WORD_W-1:0]  pool_words [STORE_WORDS];
  int unsigned        next_free_pg;
  logic [PN_W-1:0]    pool_base;
  logic [COUNT_W-1:0] pool_count;
  logic [WIDX_W-1:0]  written_words [$];
  logic [26:0]        hot_prefixes [$];
  result_t            pending_results [$];
  int unsigned        mismatch_count;
  int unsigned        stall_hold;
  bit                 pace_on;

  four_level_page_table_builder #(
    .POOL_PAGES(POOL_PAGES)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .func_i       (func_i),
    .page_number_i(page_number_i),
    .page_flags_i (page_flags_i),
    .word_index_i (word_index_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .read_data_o  (read_data_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("FAIL four_level_page_table_builder");
    $finish;
  end

  function automatic void note_word(int unsigned w);
    written_words.push_back(WIDX_W'(w));
    if (written_words.size() > 256) void'(written_words.pop_front());
  endfunction

  // follow the descriptor at (page, slot), or take and clear a new page if it is empty
  function automatic logic descend(input int unsigned page, input logic [IDX_W-1:0] slot,
                                   output int unsigned child);
    int unsigned       w;
    int unsigned       lim;
    logic [WORD_W-1:0] d;
    logic [PN_W-1:0]   rel;
    w = page * ENTRIES_PER_TABLE + slot;
    d = pool_words[w];
    lim = (pool_count > POOL_PAGES) ? POOL_PAGES : pool_count;
    child = 0;
    if (d == '0) begin
      if (next_free_pg >= lim) return 1'b0;
      for (int j = 0; j < ENTRIES_PER_TABLE; j++)
        pool_words[next_free_pg * ENTRIES_PER_TABLE + j] = '0;
      pool_words[w] = {16'h0, pool_base + PN_W'(next_free_pg), 12'h0} | TABLE_DESC;
      note_word(w);
      child = next_free_pg;
      next_free_pg++;
      return 1'b1;
    end
    rel = d[47:12] - pool_base;
    if (rel >= PN_W'(next_free_pg)) return 1'b0;
    child = int'(rel);
    return 1'b1;
  endfunction

  function automatic logic map_page(logic [PN_W-1:0] pn, logic [FLAGS_W-1:0] fl);
    int unsigned p1;
    int unsigned p2;
    int unsigned p3;
    bit          known;
    if (!descend(0, pn[35:27], p1) || !descend(p1, pn[26:18], p2) ||
        !descend(p2, pn[17:9], p3))
      return 1'b1;
    pool_words[p3 * ENTRIES_PER_TABLE + pn[8:0]] = {16'h0, pn, fl};
    note_word(p3 * ENTRIES_PER_TABLE + pn[8:0]);
    known = 1'b0;
    foreach (hot_prefixes[k]) if (hot_prefixes[k] == pn[35:9]) known = 1'b1;
    if (!known && hot_prefixes.size() < 32) hot_prefixes.push_back(pn[35:9]);
    return 1'b0;
  endfunction

  // call at a falling edge; returns at a falling edge with valid still high
  task automatic send_item(func_e f, logic [PN_W-1:0] pn, logic [FLAGS_W-1:0] fl,
                           logic [WIDX_W-1:0] wi);
    result_t want;
    while (pace_on && $urandom_range(0, 99) < 37) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    func_i        <= f;
    page_number_i <= pn;
    page_flags_i  <= fl;
    word_index_i  <= wi;
    do @(posedge clk_i); while (in_stall_o);
    want.status    = 1'b0;
    want.read_data = '0;
    if (f == FUNC_READ) want.read_data = pool_words[wi];
    else want.status = map_page(pn, fl);
    pending_results.push_back(want);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == REG_POOL_BASE) pool_base = val;
    else if (idx == REG_POOL_COUNT) pool_count = val[COUNT_W-1:0];
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic random_item();
    logic [63:0]       raw;
    logic [26:0]       prefix;
    logic [WIDX_W-1:0] wi;
    int unsigned       pick;
    raw = {$urandom(), $urandom()};
    pick = $urandom_range(0, 99);
    wi = WIDX_W'($urandom_range(0, STORE_WORDS - 1));
    prefix = hot_prefixes[$urandom_range(0, hot_prefixes.size() - 1)];
    if (pick < 30) begin
      if (written_words.size() != 0 && $urandom_range(0, 1) == 1)
        wi = written_words[$urandom_range(0, written_words.size() - 1)];
      else
        wi = {4'($urandom_range(0, next_free_pg - 1)), 9'($urandom_range(0, 511))};
      send_item(FUNC_READ, raw[35:0], raw[47:36], wi);
    end else if (pick < 85) begin
      send_item(FUNC_MAP, {prefix, raw[8:0]}, raw[47:36], wi);
    end else if (pick < 92) begin
      send_item(FUNC_MAP, {prefix[26:9], raw[17:0]}, raw[47:36], wi);
    end else begin
      send_item(FUNC_MAP, raw[35:0], raw[47:36], wi);
    end
  endtask

  task automatic test_empty_pool();
    write_reg(REG_POOL_COUNT, 36'd1);
    send_item(FUNC_MAP, '0, 12'hFFF, '0);
    drain();
    write_reg(REG_POOL_COUNT, 36'd0);
    send_item(FUNC_MAP, '1, '0, '1);
    send_item(FUNC_READ, '0, '0, 13'h0000);
    send_item(FUNC_READ, '1, '1, 13'h01FF);
    drain();
  endtask

  task automatic test_wrapped_base();
    write_reg(REG_POOL_BASE, 36'hFFFFFFFFE);
    write_reg(REG_POOL_COUNT, 36'd31);
    send_item(FUNC_MAP, '1, 12'hFFF, '0);
    send_item(FUNC_MAP, '0, 12'h000, '1);
    send_item(FUNC_MAP, {27'h7FFFFFF, 9'h000}, 12'h5A5, '0);
    send_item(FUNC_READ, '0, '0, 13'h01FF);
    send_item(FUNC_READ, '0, '0, 13'h03FF);
    send_item(FUNC_READ, '0, '0, 13'h05FF);
    send_item(FUNC_READ, '0, '0, 13'h07FF);
    send_item(FUNC_READ, '0, '0, 13'h0600);
    send_item(FUNC_READ, '0, '0, 13'h0000);
    drain();
  endtask

  task automatic test_page_limit();
    write_reg(REG_POOL_COUNT, 36'd8);
    send_item(FUNC_MAP, {9'h0AA, 27'h0}, 12'h003, '0);
    send_item(FUNC_MAP, {9'h0AA, 27'h0}, 12'h003, '0);
    send_item(FUNC_MAP, {27'h7FFFFFF, 9'h055}, 12'h7F0, '0);
    send_item(FUNC_READ, '0, '0, 13'h0E00);
    send_item(FUNC_READ, '0, '0, 13'h00AA);
    drain();
  endtask

  task automatic test_stale_pointer();
    write_reg(REG_POOL_BASE, 36'h123456789);
    send_item(FUNC_MAP, '1, 12'h00F, '0);
    send_item(FUNC_MAP, {9'h011, 27'h0}, 12'h00F, '0);
    send_item(FUNC_READ, '0, '0, 13'h01FF);
    drain();
    write_reg(REG_POOL_BASE, 36'hFFFFFFFFE);
    send_item(FUNC_MAP, '1, 12'h0F0, '0);
    drain();
  endtask

  task automatic test_backpressure();
    write_reg(REG_POOL_COUNT, 36'd16);
    @(posedge clk_i);
    stall_hold = 300;
    @(negedge clk_i);
    repeat (40) random_item();
    drain();
  endtask

  task automatic test_random_phases();
    repeat (700) random_item();
    drain();
    write_reg(REG_POOL_COUNT, 36'd31);
    pace_on = 1'b0;
    repeat (500) random_item();
    drain();
    pace_on = 1'b1;
    write_reg(REG_POOL_BASE, 36'h0);
    repeat (350) random_item();
    drain();
    write_reg(REG_POOL_BASE, 36'hFFFFFFFFE);
    write_reg(REG_POOL_COUNT, 36'd16);
    repeat (300) random_item();
    drain();
  endtask

  always @(negedge clk_i) begin
    if (stall_hold != 0) begin
      out_stall_i <= 1'b1;
      stall_hold  <= stall_hold - 1;
    end else begin
      out_stall_i <= pace_on && ($urandom_range(0, 99) < 37);
    end
  end

  always @(posedge clk_i) begin : check_results
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected word, expected none, got status %0b data %h",
                 $time, status_o, read_data_o);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (status_o !== want.status) begin
          $display("%0t: status expected %0b got %0b", $time, want.status, status_o);
          mismatch_count++;
        end
        if (read_data_o !== want.read_data) begin
          $display("%0t: read_data expected %h got %h", $time, want.read_data, read_data_o);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    func_i        = FUNC_MAP;
    page_number_i = '0;
    page_flags_i  = '0;
    word_index_i  = '0;
    out_stall_i   = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = REG_POOL_BASE;
    cfg_data_i    = '0;
    stall_hold    = 0;
    pace_on       = 1'b1;
    mismatch_count = 0;
    foreach (pool_words[i]) pool_words[i] = '0;
    next_free_pg = 1;
    pool_base    = '0;
    pool_count   = POOL_COUNT_RESET;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    test_empty_pool();
    test_wrapped_base();
    test_page_limit();
    test_stale_pointer();
    test_backpressure();
    test_random_phases();
    drain();
    if (mismatch_count == 0 && pending_results.size() == 0)
      $display("PASS four_level_page_table_builder");
    else
      $display("FAIL four_level_page_table_builder");
    $finish;
  end

endmodule
